FILE: hdl/binary_image_component_labeler_macros.svh
// assertion macros for the component labeler
`ifndef BINARY_IMAGE_COMPONENT_LABELER_MACROS_SVH
`define BINARY_IMAGE_COMPONENT_LABELER_MACROS_SVH
`ifndef SYNTHESIS
`define BICL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("labeler check failed");
`define BICL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("labeler check failed");
`else
`define BICL_ASSERT_IMP(label, clk, rst, ante, cons)
`define BICL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/bicl_pkg.sv
// shared constants for the component labeler
package bicl_pkg;

   // field and register widths
   localparam int SIZE_W    = 9;
   localparam int LABEL_W   = 16;
   localparam int CSR_IDX_W = 2;

   // default geometry and size register reset value
   localparam int DEF_MAX_ROWS = 256;
   localparam int DEF_MAX_COLS = 256;
   localparam int SIZE_RST     = 256;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_EIGHT_CONNECTED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_ROWS      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_COLS      = 2'd2;

   // request function codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   // neighbor mask bit positions, in join order
   localparam int NB_N  = 0;
   localparam int NB_NW = 1;
   localparam int NB_NE = 2;
   localparam int NB_W  = 3;
   localparam int NB_CNT = 4;

endpackage

FILE: hdl/bicl_ram.sv
// single-port RAM with registered read
module bicl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/binary_image_component_labeler.sv
// union-find connected component labeler, top level
// flow: a request flagged as an error goes from S_IDLE through S_DONE to the response
//   register; a read walks S_RD, S_RP and, for a non-root, S_RL; a write stores the pixel in
//   S_PIX, then per neighbor S_NBRD, S_NBCK and, for an object neighbor, S_WALK to both roots and S_LINK.
// requests: one at a time, stalled while busy; the single-port parent RAM serves
//   one access per cycle.
// reset: synchronous, clears all control state; the parent RAM is not cleared and
//   needs no clearing pass, as only entries of the current image are read.
`include "binary_image_component_labeler_macros.svh"
module binary_image_component_labeler #(
   parameter int MAX_ROWS = bicl_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = bicl_pkg::DEF_MAX_COLS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wen,
   input  logic [bicl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bicl_pkg::SIZE_W-1:0]    csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_func,
   input  logic                           req_object_pixel,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [bicl_pkg::LABEL_W-1:0]   rsp_label,
   output logic                           rsp_is_last,
   output logic [bicl_pkg::LABEL_W-1:0]   rsp_component_count,
   output logic                           rsp_error
);

   import bicl_pkg::*;

   localparam int PIXELS   = MAX_ROWS * MAX_COLS;
   localparam int IDX_W    = $clog2(PIXELS);
   localparam int POS_W    = $clog2(PIXELS + 1);
   localparam int ENT_W    = IDX_W + 1;
   localparam int ROWS_RST = (MAX_ROWS < SIZE_RST) ? MAX_ROWS : SIZE_RST;
   localparam int COLS_RST = (MAX_COLS < SIZE_RST) ? MAX_COLS : SIZE_RST;

   typedef enum logic [10:0] {
      S_IDLE = 11'b000_0000_0001,
      S_PIX  = 11'b000_0000_0010,
      S_NBRD = 11'b000_0000_0100,
      S_NBCK = 11'b000_0000_1000,
      S_WALK = 11'b000_0001_0000,
      S_LINK = 11'b000_0010_0000,
      S_RD   = 11'b000_0100_0000,
      S_RP   = 11'b000_1000_0000,
      S_RL   = 11'b001_0000_0000,
      S_DONE = 11'b010_0000_0000,
      S_SPARE = 11'b100_0000_0000
   } state_type;

   // size register write with clamping to 1..max
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input int max_v);
      logic [SIZE_W-1:0] s;
      s = v;
      if (s == '0) begin
         s = SIZE_W'(1);
      end
      if (int'(s) > max_v) begin
         s = SIZE_W'(max_v);
      end
      return s;
   endfunction

   state_type            state_ff, state_in;
   logic                 eight_ff, eight_in;
   logic [SIZE_W-1:0]    rows_ff, rows_in;
   logic [SIZE_W-1:0]    cols_ff, cols_in;
   logic [POS_W-1:0]     wpos_ff, wpos_in;
   logic [POS_W-1:0]     rpos_ff, rpos_in;
   logic [SIZE_W-1:0]    wcol_ff, wcol_in;
   logic                 wfirst_ff, wfirst_in;
   logic                 readout_ff, readout_in;
   logic [IDX_W-1:0]     nlabel_ff, nlabel_in;
   logic                 obj_ff, obj_in;
   logic [NB_CNT-1:0]    mask_ff, mask_in;
   logic [IDX_W-1:0]     x_ff, x_in;
   logic [IDX_W-1:0]     a_ff, a_in;
   logic [IDX_W-1:0]     b_ff, b_in;
   logic                 walkcur_ff, walkcur_in;
   logic [LABEL_W-1:0]   res_label_ff, res_label_in;
   logic                 res_last_ff, res_last_in;
   logic [LABEL_W-1:0]   res_count_ff, res_count_in;
   logic                 res_error_ff, res_error_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LABEL_W-1:0]   rsp_label_ff, rsp_label_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [LABEL_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 rsp_error_ff, rsp_error_in;

   logic                 ram_we;
   logic [IDX_W-1:0]     ram_addr;
   logic [ENT_W-1:0]     ram_wdata;
   logic [ENT_W-1:0]     ram_rdata;
   logic                 rd_obj;
   logic [IDX_W-1:0]     rd_par;

   logic [2*SIZE_W-1:0]  area;
   logic [POS_W-1:0]     total_w;
   logic [IDX_W-1:0]     widx;
   logic [IDX_W-1:0]     ridx;
   logic [IDX_W-1:0]     colsx;
   logic                 req_accept;
   logic                 rsp_free;
   logic                 rd_fin;
   logic [IDX_W-1:0]     rd_lab;
   logic [POS_W-1:0]     wpos_nx;
   logic [POS_W-1:0]     rpos_nx;
   logic                 restart;

   // parent and object store, one entry per pixel
   bicl_ram #(
      .WIDTH (ENT_W),
      .DEPTH (PIXELS)
   ) u_parent_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign rd_obj = ram_rdata[IDX_W];
   assign rd_par = ram_rdata[IDX_W-1:0];

   // image size and current positions
   assign area    = {{SIZE_W{1'b0}}, rows_ff} * {{SIZE_W{1'b0}}, cols_ff};
   assign total_w = POS_W'(area);
   assign widx    = wpos_ff[IDX_W-1:0];
   assign ridx    = rpos_ff[IDX_W-1:0];
   assign colsx   = IDX_W'(cols_ff);
   assign wpos_nx = wpos_ff + POS_W'(1);
   assign rpos_nx = rpos_ff + POS_W'(1);

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && (state_ff == S_IDLE);
   assign rsp_free   = !(rsp_valid_ff && rsp_stall);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      eight_in     = eight_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      wpos_in      = wpos_ff;
      rpos_in      = rpos_ff;
      wcol_in      = wcol_ff;
      wfirst_in    = wfirst_ff;
      readout_in   = readout_ff;
      nlabel_in    = nlabel_ff;
      obj_in       = obj_ff;
      mask_in      = mask_ff;
      x_in         = x_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      walkcur_in   = walkcur_ff;
      res_label_in = res_label_ff;
      res_last_in  = res_last_ff;
      res_count_in = res_count_ff;
      res_error_in = res_error_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_label_in = rsp_label_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_count_in = rsp_count_ff;
      rsp_error_in = rsp_error_ff;
      ram_we       = 1'b0;
      ram_addr     = widx;
      ram_wdata    = {1'b1, widx};
      rd_fin       = 1'b0;
      rd_lab       = '0;
      restart      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               res_label_in = '0;
               res_last_in  = 1'b0;
               res_count_in = '0;
               res_error_in = 1'b0;
               obj_in       = req_object_pixel;
               if (req_func == FUNC_WRITE) begin
                  if (readout_ff || (wpos_ff >= total_w)) begin
                     res_error_in = 1'b1;
                     state_in     = S_DONE;
                  end else begin
                     state_in = S_PIX;
                  end
               end else begin
                  if (!readout_ff || (rpos_ff >= total_w)) begin
                     res_error_in = 1'b1;
                     state_in     = S_DONE;
                  end else begin
                     state_in = S_RD;
                  end
               end
            end
         end

         // store the new pixel as its own root and pick the neighbors to join
         S_PIX: begin
            ram_we    = 1'b1;
            ram_addr  = widx;
            ram_wdata = {obj_ff, widx};
            mask_in   = '0;
            if (obj_ff) begin
               mask_in[NB_N]  = !wfirst_ff;
               mask_in[NB_NW] = !wfirst_ff && eight_ff && (wcol_ff != '0);
               mask_in[NB_NE] = !wfirst_ff && eight_ff &&
                                (wcol_ff != (cols_ff - SIZE_W'(1)));
               mask_in[NB_W]  = (wcol_ff != '0);
            end
            state_in = S_NBRD;
         end

         // read the next neighbor in join order, or close the write
         S_NBRD: begin
            if (mask_ff != '0) begin
               if (mask_ff[NB_N]) begin
                  ram_addr      = widx - colsx;
                  mask_in[NB_N] = 1'b0;
               end else if (mask_ff[NB_NW]) begin
                  ram_addr       = widx - colsx - IDX_W'(1);
                  mask_in[NB_NW] = 1'b0;
               end else if (mask_ff[NB_NE]) begin
                  ram_addr       = widx - colsx + IDX_W'(1);
                  mask_in[NB_NE] = 1'b0;
               end else begin
                  ram_addr      = widx - IDX_W'(1);
                  mask_in[NB_W] = 1'b0;
               end
               x_in     = ram_addr;
               state_in = S_NBCK;
            end else begin
               wpos_in = wpos_nx;
               if (wcol_ff == (cols_ff - SIZE_W'(1))) begin
                  wcol_in   = '0;
                  wfirst_in = 1'b0;
               end else begin
                  wcol_in = wcol_ff + SIZE_W'(1);
               end
               if (wpos_nx >= total_w) begin
                  readout_in = 1'b1;
               end
               state_in = S_DONE;
            end
         end

         // background neighbors are skipped, object neighbors start a root search
         S_NBCK: begin
            if (!rd_obj) begin
               state_in = S_NBRD;
            end else if (rd_par < x_ff) begin
               x_in       = rd_par;
               ram_addr   = rd_par;
               walkcur_in = 1'b0;
               state_in   = S_WALK;
            end else begin
               b_in       = x_ff;
               x_in       = widx;
               ram_addr   = widx;
               walkcur_in = 1'b1;
               state_in   = S_WALK;
            end
         end

         // follow parent links, one per cycle, neighbor root first then own root
         S_WALK: begin
            if (rd_par < x_ff) begin
               x_in     = rd_par;
               ram_addr = rd_par;
            end else if (!walkcur_ff) begin
               b_in       = x_ff;
               x_in       = widx;
               ram_addr   = widx;
               walkcur_in = 1'b1;
            end else begin
               a_in     = x_ff;
               state_in = S_LINK;
            end
         end

         // hang the larger root under the smaller one
         S_LINK: begin
            ram_we = 1'b1;
            if (a_ff > b_ff) begin
               ram_addr  = a_ff;
               ram_wdata = {1'b1, b_ff};
            end else begin
               ram_addr  = b_ff;
               ram_wdata = {1'b1, a_ff};
            end
            state_in = S_NBRD;
         end

         // readout: fetch the pixel entry
         S_RD: begin
            ram_addr = ridx;
            state_in = S_RP;
         end

         // a root takes a fresh label, other pixels fetch their parent's label
         S_RP: begin
            if (!rd_obj) begin
               rd_fin = 1'b1;
            end else if (rd_par >= ridx) begin
               nlabel_in = nlabel_ff + IDX_W'(1);
               rd_lab    = nlabel_in;
               ram_we    = 1'b1;
               ram_addr  = ridx;
               ram_wdata = {1'b1, nlabel_in};
               rd_fin    = 1'b1;
            end else begin
               ram_addr = rd_par;
               state_in = S_RL;
            end
         end

         S_RL: begin
            rd_lab    = rd_par;
            ram_we    = 1'b1;
            ram_addr  = ridx;
            ram_wdata = {1'b1, rd_par};
            rd_fin    = 1'b1;
         end

         // hand the result to the response register once it is free
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_label_in = res_label_ff;
               rsp_last_in  = res_last_ff;
               rsp_count_in = res_count_ff;
               rsp_error_in = res_error_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // close a read request
      if (rd_fin) begin
         res_label_in = LABEL_W'(rd_lab);
         rpos_in      = rpos_nx;
         if (rpos_nx >= total_w) begin
            res_last_in  = 1'b1;
            res_count_in = LABEL_W'(nlabel_in);
            restart      = 1'b1;
         end
         state_in = S_DONE;
      end

      // register writes
      if (csr_wen) begin
         case (csr_index)
            CSR_EIGHT_CONNECTED: begin
               eight_in = csr_wdata[0];
               restart  = 1'b1;
            end
            CSR_IMAGE_ROWS: begin
               rows_in = clamp_size(csr_wdata, MAX_ROWS);
               restart = 1'b1;
            end
            CSR_IMAGE_COLS: begin
               cols_in = clamp_size(csr_wdata, MAX_COLS);
               restart = 1'b1;
            end
            default: begin
               restart = restart;
            end
         endcase
      end

      // back to loading a new image
      if (restart) begin
         wpos_in    = '0;
         rpos_in    = '0;
         wcol_in    = '0;
         wfirst_in  = 1'b1;
         readout_in = 1'b0;
         nlabel_in  = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         eight_ff     <= 1'b0;
         rows_ff      <= SIZE_W'(ROWS_RST);
         cols_ff      <= SIZE_W'(COLS_RST);
         wpos_ff      <= '0;
         rpos_ff      <= '0;
         wcol_ff      <= '0;
         wfirst_ff    <= 1'b1;
         readout_ff   <= 1'b0;
         nlabel_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         eight_ff     <= eight_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         wpos_ff      <= wpos_in;
         rpos_ff      <= rpos_in;
         wcol_ff      <= wcol_in;
         wfirst_ff    <= wfirst_in;
         readout_ff   <= readout_in;
         nlabel_ff    <= nlabel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      obj_ff       <= obj_in;
      mask_ff      <= mask_in;
      x_ff         <= x_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      walkcur_ff   <= walkcur_in;
      res_label_ff <= res_label_in;
      res_last_ff  <= res_last_in;
      res_count_ff <= res_count_in;
      res_error_ff <= res_error_in;
      rsp_label_ff <= rsp_label_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_label           = rsp_label_ff;
   assign rsp_is_last         = rsp_last_ff;
   assign rsp_component_count = rsp_count_ff;
   assign rsp_error           = rsp_error_ff;

   // checks
   `BICL_ASSERT_IMP(a_load_in_range, clock, reset, !readout_ff, wpos_ff < total_w)
   `BICL_ASSERT_IMP(a_read_in_range, clock, reset, readout_ff, rpos_ff < total_w)
   `BICL_ASSERT_IMP(a_link_roots, clock, reset, state_ff == S_LINK, (b_ff < widx) && (a_ff <= widx))
   `BICL_ASSERT_NEXT(a_done_issues, clock, reset, (state_ff == S_DONE) && rsp_free, rsp_valid_ff && (state_ff == S_IDLE))

endmodule

FILE: dv/binary_image_component_labeler_checker.sv
// response checker and label predictor for the component labeler testbench
module binary_image_component_labeler_checker #(
   parameter int MAX_ROWS = bicl_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = bicl_pkg::DEF_MAX_COLS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wen,
   input  logic [bicl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bicl_pkg::SIZE_W-1:0]    csr_wdata,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic                           req_func,
   input  logic                           req_object_pixel,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [bicl_pkg::LABEL_W-1:0]   rsp_label,
   input  logic                           rsp_is_last,
   input  logic [bicl_pkg::LABEL_W-1:0]   rsp_component_count,
   input  logic                           rsp_error,
   output int                             failures,
   output int                             outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import bicl_pkg::*;

   localparam int PIXELS = MAX_ROWS * MAX_COLS;

   typedef struct packed {
      logic [LABEL_W-1:0] label;
      logic               is_last;
      logic [LABEL_W-1:0] count;
      logic               error;
   } label_rsp_type;

   // shadow of the labeler state
   int unsigned parent_of [PIXELS];
   bit          is_object [PIXELS];
   int unsigned load_pos;
   int unsigned scan_pos;
   int unsigned labels_issued;
   bit          scanning;
   bit          eight_conn;
   int unsigned rows_cfg;
   int unsigned cols_cfg;

   label_rsp_type expected_labels [$];

   function automatic void restart_image();
      load_pos      = 0;
      scan_pos      = 0;
      labels_issued = 0;
      scanning      = 1'b0;
   endfunction

   // zero means one, anything past the array size saturates
   function automatic int unsigned clamp_dim(logic [SIZE_W-1:0] v, int unsigned lim);
      int unsigned s;
      s = 32'(v);
      if (s == 0)
         s = 1;
      if (s > lim)
         s = lim;
      return s;
   endfunction

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
      case (idx)
         CSR_EIGHT_CONNECTED: begin
            eight_conn = data[0];
            restart_image();
         end
         CSR_IMAGE_ROWS: begin
            rows_cfg = clamp_dim(data, MAX_ROWS);
            restart_image();
         end
         CSR_IMAGE_COLS: begin
            cols_cfg = clamp_dim(data, MAX_COLS);
            restart_image();
         end
         default: ;
      endcase
   endfunction

   // parents always sit at a smaller index, so the walk ends
   function automatic int unsigned find_root(int unsigned x);
      while (x < PIXELS && parent_of[x] != x && parent_of[x] < x)
         x = parent_of[x];
      return x;
   endfunction

   // union by smaller root
   function automatic void join_neighbor(int unsigned cur, int unsigned nb);
      int unsigned a;
      int unsigned b;
      if (nb < PIXELS && is_object[nb]) begin
         a = find_root(cur);
         b = find_root(nb);
         if (a > b)
            parent_of[a] = b;
         else
            parent_of[b] = a;
      end
   endfunction

   function automatic label_rsp_type predict_label(logic func, logic obj);
      label_rsp_type r;
      int unsigned   total;
      int unsigned   pos;
      int unsigned   row;
      int unsigned   col;
      int unsigned   north;
      int unsigned   p;
      int unsigned   lab;
      r     = '0;
      lab   = 0;
      total = rows_cfg * cols_cfg;
      if (func == FUNC_WRITE) begin
         // write out of sequence is dropped
         if (scanning || load_pos >= total) begin
            r.error = 1'b1;
            return r;
         end
         pos = load_pos;
         row = pos / cols_cfg;
         col = pos % cols_cfg;
         is_object[pos] = obj;
         if (obj) begin
            parent_of[pos] = pos;
            if (row != 0) begin
               north = pos - cols_cfg;
               join_neighbor(pos, north);
               if (eight_conn) begin
                  if (col != 0)
                     join_neighbor(pos, north - 1);
                  if (col != cols_cfg - 1)
                     join_neighbor(pos, north + 1);
               end
            end
            if (col != 0)
               join_neighbor(pos, pos - 1);
         end
         load_pos = pos + 1;
         if (load_pos >= total)
            scanning = 1'b1;
      end else begin
         // read while still loading is dropped
         if (!scanning || scan_pos >= total) begin
            r.error = 1'b1;
            return r;
         end
         pos = scan_pos;
         if (is_object[pos]) begin
            p = parent_of[pos];
            if (p >= pos) begin
               labels_issued++;
               lab = labels_issued;
            end else begin
               // parent already carries its final label
               lab = parent_of[p];
            end
            parent_of[pos] = lab;
         end
         r.label  = lab[LABEL_W-1:0];
         scan_pos = pos + 1;
         if (scan_pos >= total) begin
            r.is_last = 1'b1;
            r.count   = labels_issued[LABEL_W-1:0];
            restart_image();
         end
      end
      return r;
   endfunction

   task automatic compare_field(string what, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, seen);
         failures++;
      end
   endtask

   // track config, predict on each accepted request, check each response
   always @(posedge clock) begin
      label_rsp_type want;
      if (reset) begin
         eight_conn = 1'b0;
         rows_cfg   = (MAX_ROWS < SIZE_RST) ? MAX_ROWS : SIZE_RST;
         cols_cfg   = (MAX_COLS < SIZE_RST) ? MAX_COLS : SIZE_RST;
         restart_image();
         expected_labels.delete();
         failures = 0;
      end else begin
         if (csr_wen)
            apply_csr(csr_index, csr_wdata);
         if (rsp_valid && !rsp_stall) begin
            if (expected_labels.size() == 0) begin
               $display("%0t: response with nothing expected: label %0d last %0b count %0d error %0b",
                        $time, rsp_label, rsp_is_last, rsp_component_count, rsp_error);
               failures++;
            end else begin
               want = expected_labels.pop_front();
               compare_field("label", 32'(want.label), 32'(rsp_label));
               compare_field("is_last", 32'(want.is_last), 32'(rsp_is_last));
               compare_field("component_count", 32'(want.count),
                             32'(rsp_component_count));
               compare_field("error", 32'(want.error), 32'(rsp_error));
            end
         end
         if (req_valid && !req_stall)
            expected_labels.push_back(predict_label(req_func, req_object_pixel));
      end
      outstanding <= expected_labels.size();
   end

endmodule

FILE: dv/binary_image_component_labeler_test.sv
// testbench top for the component labeler: clock, reset, request and response traffic
module binary_image_component_labeler_test;
   timeunit 1ns;
   timeprecision 1ps;
   import bicl_pkg::*;

   localparam int SIM_LIMIT    = 1000000;
   localparam int IDLE_PCT     = 35;
   localparam int LONG_HOLD    = 300;
   localparam int RANDOM_ITEMS = 120;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_wen;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SIZE_W-1:0]    csr_wdata;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_func;
   logic                 req_object_pixel;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [LABEL_W-1:0]   rsp_label;
   logic                 rsp_is_last;
   logic [LABEL_W-1:0]   rsp_component_count;
   logic                 rsp_error;

   int failures;
   int outstanding;

   bit calm;
   int holds_asked;
   int holds_done;
   int image_pixels;
   int requests_sent;
   int images_read;
   int csr_writes;
   int cycle_count;

   always #6 clock = ~clock;

   binary_image_component_labeler dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wen             (csr_wen),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_object_pixel    (req_object_pixel),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_label           (rsp_label),
      .rsp_is_last         (rsp_is_last),
      .rsp_component_count (rsp_component_count),
      .rsp_error           (rsp_error)
   );

   binary_image_component_labeler_checker label_check (
      .clock               (clock),
      .reset               (reset),
      .csr_wen             (csr_wen),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_object_pixel    (req_object_pixel),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_label           (rsp_label),
      .rsp_is_last         (rsp_is_last),
      .rsp_component_count (rsp_component_count),
      .rsp_error           (rsp_error),
      .failures            (failures),
      .outstanding         (outstanding)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= SIM_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses still due", cycle_count, outstanding);
         $display("Some tests failed");
         $finish;
      end
   end

   // response side: random stalls, calm stretches, one long hold-off on request
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_done != holds_asked) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            holds_done++;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // one request through the handshake, with an optional idle gap first
   task automatic send_request(input logic func, input logic obj);
      bit taken;
      if (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= func;
      req_object_pixel <= obj;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      requests_sent++;
   endtask

   // stop offering and wait for every response
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic int used_size(logic [SIZE_W-1:0] v, int lim);
      if (v == 0)
         return 1;
      return (v > lim) ? lim : int'(v);
   endfunction

   // program all registers back to back while idle; unused index goes last
   task automatic configure(input bit eight, input logic [SIZE_W-1:0] rows,
                            input logic [SIZE_W-1:0] cols);
      drain();
      csr_wen   <= 1'b1;
      csr_index <= CSR_EIGHT_CONNECTED;
      csr_wdata <= SIZE_W'(eight);
      @(posedge clock);
      csr_index <= CSR_IMAGE_ROWS;
      csr_wdata <= rows;
      @(posedge clock);
      csr_index <= CSR_IMAGE_COLS;
      csr_wdata <= cols;
      @(posedge clock);
      csr_index <= CSR_UNUSED;
      csr_wdata <= SIZE_W'($urandom_range(511));
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
      csr_writes  += 4;
      image_pixels = used_size(rows, DEF_MAX_ROWS) * used_size(cols, DEF_MAX_COLS);
   endtask

   task automatic load_pixels(input int count, input int fill_pct);
      for (int i = 0; i < count; i++)
         send_request(FUNC_WRITE, $urandom_range(99) < fill_pct);
   endtask

   task automatic read_labels(input int count);
      for (int i = 0; i < count; i++)
         send_request(FUNC_READ, 1'($urandom_range(1)));
   endtask

   function automatic logic [SIZE_W-1:0] pick_dim();
      if ($urandom_range(19) == 0)
         return '0;
      return SIZE_W'($urandom_range(8, 1));
   endfunction

   // stimulus
   initial begin
      logic [5:0] pat;
      int         goal;
      int         style;
      int         cut;
      bit         must_cfg;
      reset            <= 1'b1;
      csr_wen          <= 1'b0;
      csr_index        <= CSR_EIGHT_CONNECTED;
      csr_wdata        <= '0;
      req_valid        <= 1'b0;
      req_func         <= FUNC_WRITE;
      req_object_pixel <= 1'b0;
      calm             = 1'b0;
      holds_asked      = 0;
      requests_sent    = 0;
      images_read      = 0;
      csr_writes       = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // 2x2, 4-connected, with a read while loading, a write while reading
      // out and a read after the final one
      configure(1'b0, 9'd2, 9'd2);
      send_request(FUNC_READ, 1'b1);
      pat = 6'b001011;
      for (int i = 0; i < 4; i++)
         send_request(FUNC_WRITE, pat[i]);
      send_request(FUNC_WRITE, 1'b1);
      read_labels(4);
      send_request(FUNC_READ, 1'b0);
      images_read++;

      // 2x3, 8-connected: the lower middle pixel joins both diagonals
      configure(1'b1, 9'd2, 9'd3);
      pat = 6'b010101;
      for (int i = 0; i < 6; i++)
         send_request(FUNC_WRITE, pat[i]);
      read_labels(6);
      images_read++;

      // size registers at zero give a single pixel
      configure(1'b0, 9'd0, 9'd0);
      send_request(FUNC_WRITE, 1'b1);
      read_labels(1);
      images_read++;

      // random images, mostly complete, some abandoned by a reconfiguration
      goal     = requests_sent + RANDOM_ITEMS;
      must_cfg = 1'b1;
      while (requests_sent < goal) begin
         if (must_cfg || $urandom_range(99) < 40) begin
            configure(1'($urandom_range(1)), pick_dim(), pick_dim());
            must_cfg = 1'b0;
         end
         calm = ($urandom_range(7) == 0);
         if (holds_asked == 0 && requests_sent >= goal - RANDOM_ITEMS / 2)
            holds_asked = 1;
         if ($urandom_range(9) == 0)
            send_request(FUNC_READ, 1'($urandom_range(1)));
         style = $urandom_range(99);
         if (style < 8) begin
            load_pixels($urandom_range(image_pixels - 1, 0), $urandom_range(95, 5));
            must_cfg = 1'b1;
         end else begin
            load_pixels(image_pixels, $urandom_range(95, 5));
            cut = $urandom_range(image_pixels - 1, 0);
            read_labels(cut);
            if (style < 16) begin
               must_cfg = 1'b1;
            end else begin
               if ($urandom_range(9) == 0)
                  send_request(FUNC_WRITE, 1'($urandom_range(1)));
               read_labels(image_pixels - cut);
               images_read++;
            end
         end
      end

      // saturated rows as a single column, loaded with no idling on either side;
      // a few reads show the readout started, then a write is refused
      calm = 1'b1;
      configure(1'b1, 9'h1FF, 9'd1);
      load_pixels(image_pixels, 60);
      read_labels(4);
      send_request(FUNC_WRITE, 1'b1);
      calm = 1'b0;

      drain();
      repeat (16) @(posedge clock);
      $display("%0d requests, %0d images read out in full, %0d register writes",
               requests_sent, images_read, csr_writes);
      $display("both connectivities, sizes 1x1 up to saturated 256x1, out-of-sequence requests");
      if (failures == 0 && outstanding == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/bicl_pkg.sv
hdl/bicl_ram.sv
hdl/binary_image_component_labeler.sv
dv/binary_image_component_labeler_checker.sv
dv/binary_image_component_labeler_test.sv
